/* rtl/rmj_pkg.sv */
package rmj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 17;
    localparam int IN_W      = 128;
    localparam int OUT_W     = 192;
    localparam int USER_W    = 1;

    localparam logic [CFG_W-1:0] CFG_RESET = 17'd7;

    // stage numbering: stage 1 is the input register, NSTG the output register
    localparam int STG_MUL  = 2;
    localparam int STG_SUM  = 3;
    localparam int STG_PP   = 4;
    localparam int STG_PSUM = 5;
    localparam int SQ_FIRST = 4;
    localparam int SQ_LAST  = 35;
    localparam int Q_FIRST  = 6;
    localparam int Q_LAST   = 53;
    localparam int A_FIRST  = 36;
    localparam int A_LAST   = 52;
    localparam int U_INIT   = 54;
    localparam int U_FIRST  = 55;
    localparam int U_LAST   = 86;
    localparam int NSTG     = 87;

    typedef struct packed {
        logic        npx;
        logic        npy;
        logic        nvx;
        logic        nvy;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [63:0] pxx;
        logic [63:0] pyy;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] s;
        logic        clamped;
        logic [63:0] c;
        logic        nc;
        logic [63:0] ppxl;
        logic [63:0] ppxh;
        logic [63:0] ppyl;
        logic [63:0] ppyh;
        logic [32:0] sq_rem;
        logic [31:0] sq_root;
        logic [63:0] sq_src;
        logic [63:0] bx_rem;
        logic [63:0] by_rem;
        logic [31:0] bx_q;
        logic [31:0] by_q;
        logic [63:0] qx_rem;
        logic [63:0] qy_rem;
        logic [47:0] qx_src;
        logic [47:0] qy_src;
        logic [47:0] qx_q;
        logic [47:0] qy_q;
        logic        qx_ovf;
        logic        qy_ovf;
        logic [31:0] ax_rem;
        logic [31:0] ay_rem;
        logic        ax_src;
        logic        ay_src;
        logic [16:0] ax_q;
        logic [16:0] ay_q;
        logic [31:0] ux_rem;
        logic [31:0] uy_rem;
        logic [15:0] ux_src;
        logic [15:0] uy_src;
        logic [31:0] ux_q;
        logic [31:0] uy_q;
        logic        ux_ovf;
        logic        uy_ovf;
        logic [OUT_W-1:0] odata;
        logic        oflag;
    } t_pipe;

endpackage

/* rtl/radar_measurement_jacobian_unit.sv */
// Radar measurement Jacobian for a 2D constant-velocity state in signed Q16.16.
// One state vector is taken per clock while the output is not held; the depth
// is set by the rate path, with its 48-step and 32-step divisions, while the
// 32-step square root is followed by the 17-step range division, one restoring
// step per pipeline stage. When the output is held the whole pipeline holds
// with it. r^2 is clamped to the configured floor before any division and
// range_clamped marks that. The floor register may be written at any time but
// is sampled at stage 3.
module radar_measurement_jacobian_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y
    input  logic [rmj_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy
    output logic [rmj_pkg::OUT_W-1:0] m_axis_tdata,
    // range_clamped
    output logic [rmj_pkg::USER_W-1:0] m_axis_tuser,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rmj_pkg::CFG_W-1:0] i_cfg_data
);
    import rmj_pkg::*;

    logic [CFG_W-1:0] r_floor;
    logic [CFG_W-1:0] n_floor;
    t_pipe            r_pipe [1:NSTG];
    t_pipe            n_pipe [1:NSTG];
    logic [NSTG:1]    r_vld;
    logic             adv;

    function automatic logic [64:0] f_div64(input logic [63:0] rem, input logic b,
                                            input logic [63:0] d);
        logic [64:0] t;
        logic [64:0] df;
        t  = {rem, b};
        df = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            f_div64 = {1'b1, df[63:0]};
        end else begin
            f_div64 = {1'b0, t[63:0]};
        end
    endfunction

    function automatic logic [32:0] f_div32(input logic [31:0] rem, input logic b,
                                            input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] df;
        t  = {rem, b};
        df = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            f_div32 = {1'b1, df[31:0]};
        end else begin
            f_div32 = {1'b0, t[31:0]};
        end
    endfunction

    // returns {root, rem}
    function automatic logic [64:0] f_sqrt(input logic [32:0] rem, input logic [31:0] root,
                                           input logic [1:0] b2);
        logic [34:0] t;
        logic [34:0] tr;
        logic [34:0] df;
        t  = {rem, b2};
        tr = {1'b0, root, 2'b01};
        df = t - tr;
        if (t >= tr) begin
            f_sqrt = {root[30:0], 1'b1, df[32:0]};
        end else begin
            f_sqrt = {root[30:0], 1'b0, t[32:0]};
        end
    endfunction

    function automatic logic [31:0] f_to_q(input logic neg, input logic ovf,
                                           input logic [31:0] mag);
        if (neg) begin
            if (ovf || mag > 32'h8000_0000) begin
                f_to_q = 32'h8000_0000;
            end else begin
                f_to_q = ~mag + 32'd1;
            end
        end else begin
            if (ovf || mag > 32'h7FFF_FFFF) begin
                f_to_q = 32'h7FFF_FFFF;
            end else begin
                f_to_q = mag;
            end
        end
    endfunction

    function automatic t_pipe f_stage(input int k, input t_pipe p,
                                      input logic [CFG_W-1:0] flr);
        t_pipe                      n;
        logic [CFG_W-1:0]           fl;
        logic [CFG_W+FRAC_BITS-1:0] thr;
        logic [63:0]                sum;
        logic                       n1;
        logic                       n2;
        logic [95:0]                pax;
        logic [95:0]                pay;
        logic [64:0]                dq;
        logic [32:0]                d32;
        logic [64:0]                sq;
        n = p;
        if (k == STG_MUL) begin
            n.pxx = p.px * p.px;
            n.pyy = p.py * p.py;
            n.m1  = p.vx * p.py;
            n.m2  = p.vy * p.px;
        end
        if (k == STG_SUM) begin
            sum = p.pxx + p.pyy;
            fl  = (flr == '0) ? CFG_W'(1) : flr;
            thr = {fl, {FRAC_BITS{1'b0}}};
            if (sum < 64'(thr)) begin
                n.s       = 64'(thr);
                n.clamped = 1'b1;
            end else begin
                n.s       = sum;
                n.clamped = 1'b0;
            end
            n1 = (p.nvx != p.npy) && (p.m1 != '0);
            n2 = (p.nvy == p.npx) && (p.m2 != '0);
            if (n1 == n2) begin
                n.c  = p.m1 + p.m2;
                n.nc = n1;
            end else if (p.m1 >= p.m2) begin
                n.c  = p.m1 - p.m2;
                n.nc = n1;
            end else begin
                n.c  = p.m2 - p.m1;
                n.nc = n2;
            end
            if (n.c == '0) begin
                n.nc = 1'b0;
            end
            n.sq_rem  = '0;
            n.sq_root = '0;
            n.sq_src  = n.s;
            n.bx_rem  = {32'd0, p.px};
            n.by_rem  = {32'd0, p.py};
            n.bx_q    = '0;
            n.by_q    = '0;
        end
        if (k == STG_PP) begin
            n.ppxl = p.px * p.c[31:0];
            n.ppxh = p.px * p.c[63:32];
            n.ppyl = p.py * p.c[31:0];
            n.ppyh = p.py * p.c[63:32];
        end
        if (k == STG_PSUM) begin
            pax      = {p.ppxh, 32'd0} + {32'd0, p.ppxl};
            pay      = {p.ppyh, 32'd0} + {32'd0, p.ppyl};
            n.qx_rem = {16'd0, pax[95:48]};
            n.qy_rem = {16'd0, pay[95:48]};
            n.qx_src = pax[47:0];
            n.qy_src = pay[47:0];
            n.qx_q   = '0;
            n.qy_q   = '0;
        end
        if (k >= SQ_FIRST && k <= SQ_LAST) begin
            sq        = f_sqrt(p.sq_rem, p.sq_root, p.sq_src[63:62]);
            n.sq_root = sq[64:33];
            n.sq_rem  = sq[32:0];
            n.sq_src  = {p.sq_src[61:0], 2'b00};
            dq        = f_div64(p.bx_rem, 1'b0, p.s);
            n.bx_rem  = dq[63:0];
            n.bx_q    = {p.bx_q[30:0], dq[64]};
            dq        = f_div64(p.by_rem, 1'b0, p.s);
            n.by_rem  = dq[63:0];
            n.by_q    = {p.by_q[30:0], dq[64]};
        end
        if (k == SQ_LAST) begin
            n.ax_rem = {1'b0, p.px[31:1]};
            n.ay_rem = {1'b0, p.py[31:1]};
            n.ax_src = p.px[0];
            n.ay_src = p.py[0];
            n.ax_q   = '0;
            n.ay_q   = '0;
        end
        if (k == Q_FIRST) begin
            n.qx_ovf = p.qx_rem >= p.s;
            n.qy_ovf = p.qy_rem >= p.s;
        end
        if (k >= Q_FIRST && k <= Q_LAST) begin
            dq       = f_div64(p.qx_rem, p.qx_src[47], p.s);
            n.qx_rem = dq[63:0];
            n.qx_q   = {p.qx_q[46:0], dq[64]};
            n.qx_src = {p.qx_src[46:0], 1'b0};
            dq       = f_div64(p.qy_rem, p.qy_src[47], p.s);
            n.qy_rem = dq[63:0];
            n.qy_q   = {p.qy_q[46:0], dq[64]};
            n.qy_src = {p.qy_src[46:0], 1'b0};
        end
        if (k >= A_FIRST && k <= A_LAST) begin
            d32      = f_div32(p.ax_rem, p.ax_src, p.sq_root);
            n.ax_rem = d32[31:0];
            n.ax_q   = {p.ax_q[15:0], d32[32]};
            n.ax_src = 1'b0;
            d32      = f_div32(p.ay_rem, p.ay_src, p.sq_root);
            n.ay_rem = d32[31:0];
            n.ay_q   = {p.ay_q[15:0], d32[32]};
            n.ay_src = 1'b0;
        end
        if (k == U_INIT) begin
            n.ux_rem = p.qx_q[47:16];
            n.uy_rem = p.qy_q[47:16];
            n.ux_src = p.qx_q[15:0];
            n.uy_src = p.qy_q[15:0];
            n.ux_ovf = p.qx_q[47:16] >= p.sq_root;
            n.uy_ovf = p.qy_q[47:16] >= p.sq_root;
            n.ux_q   = '0;
            n.uy_q   = '0;
        end
        if (k >= U_FIRST && k <= U_LAST) begin
            d32      = f_div32(p.ux_rem, p.ux_src[15], p.sq_root);
            n.ux_rem = d32[31:0];
            n.ux_q   = {p.ux_q[30:0], d32[32]};
            n.ux_src = {p.ux_src[14:0], 1'b0};
            d32      = f_div32(p.uy_rem, p.uy_src[15], p.sq_root);
            n.uy_rem = d32[31:0];
            n.uy_q   = {p.uy_q[30:0], d32[32]};
            n.uy_src = {p.uy_src[14:0], 1'b0};
        end
        if (k == NSTG) begin
            n.odata = {f_to_q(p.npx == p.nc, p.qx_ovf | p.ux_ovf, p.ux_q),
                       f_to_q(p.npy != p.nc, p.qy_ovf | p.uy_ovf, p.uy_q),
                       f_to_q(p.npx, 1'b0, p.bx_q),
                       f_to_q(~p.npy, 1'b0, p.by_q),
                       f_to_q(p.npy, 1'b0, {15'd0, p.ay_q}),
                       f_to_q(p.npx, 1'b0, {15'd0, p.ax_q})};
            n.oflag = p.clamped;
        end
        return n;
    endfunction

    assign adv           = ~r_vld[NSTG] | m_axis_tready;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;
    assign n_floor       = (i_cfg_valid & o_cfg_ready) ? i_cfg_data : r_floor;

    always_comb begin
        n_pipe[1]     = '0;
        n_pipe[1].npx = s_axis_tdata[31];
        n_pipe[1].npy = s_axis_tdata[63];
        n_pipe[1].nvx = s_axis_tdata[95];
        n_pipe[1].nvy = s_axis_tdata[127];
        n_pipe[1].px  = s_axis_tdata[31] ? ~s_axis_tdata[31:0] + 32'd1 : s_axis_tdata[31:0];
        n_pipe[1].py  = s_axis_tdata[63] ? ~s_axis_tdata[63:32] + 32'd1 : s_axis_tdata[63:32];
        n_pipe[1].vx  = s_axis_tdata[95] ? ~s_axis_tdata[95:64] + 32'd1 : s_axis_tdata[95:64];
        n_pipe[1].vy  = s_axis_tdata[127] ? ~s_axis_tdata[127:96] + 32'd1
                                          : s_axis_tdata[127:96];
    end

    for (genvar g = 2; g <= NSTG; g++) begin : g_stg
        always_comb begin
            n_pipe[g] = f_stage(g, r_pipe[g-1], r_floor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_floor <= CFG_RESET;
        end else begin
            r_floor <= n_floor;
            if (adv) begin
                r_vld <= {r_vld[NSTG-1:1], s_axis_tvalid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pipe <= n_pipe;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = r_pipe[NSTG].odata;
    assign m_axis_tuser  = r_pipe[NSTG].oflag;

endmodule

/* rtl/rmj_checker.sv */
module rmj_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [rmj_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic [rmj_pkg::USER_W-1:0] m_axis_tuser,
    input logic                       o_cfg_ready
);
    import rmj_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("held result changed");

    // an empty output slot never back-pressures the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel not ready");

    // range_dx and bearing_dy share the sign of px
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31] |->
            (m_axis_tdata[127] || m_axis_tdata[127:96] == 32'd0))
        else $error("range_dx and bearing_dy disagree in sign");

    a_rst: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind radar_measurement_jacobian_unit rmj_checker u_rmj_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import rmj_pkg::*;

    localparam int LATENCY   = 87;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [31:0] rate_dy;
        logic [31:0] rate_dx;
        logic [31:0] bearing_dy;
        logic [31:0] bearing_dx;
        logic [31:0] range_dy;
        logic [31:0] range_dx;
    } t_jac;

    typedef struct {
        t_jac jac;
        logic clamped;
    } t_jac_res;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        fixed;
        logic        clamped;
        logic [31:0] rdx;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic [USER_W-1:0]   m_axis_tuser;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    radar_measurement_jacobian_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_jac_res   jac_pending[$];
    logic [16:0] floor_reg = CFG_RESET;
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    bit         sink_hold = 1'b0;

    // ---- predictor ----
    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat_div(input logic [127:0] num, input logic [63:0] d);
        logic [127:0] q;
        q = num / {64'd0, d};
        return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    function automatic logic [31:0] to_fixed(input logic neg, input logic [63:0] mag);
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'(64'h1_0000_0000 - mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic t_jac_res jacobian(input logic [31:0] rpx, rpy, rvx, rvy);
        t_jac_res o;
        logic npx, npy, nvx, nvy, n1, n2, nc;
        logic [63:0] px, py, vx, vy, s, t, r, m1, m2, c, fl, qx, qy;
        npx = rpx[31]; npy = rpy[31]; nvx = rvx[31]; nvy = rvy[31];
        px = npx ? 64'h1_0000_0000 - rpx : {32'd0, rpx};
        py = npy ? 64'h1_0000_0000 - rpy : {32'd0, rpy};
        vx = nvx ? 64'h1_0000_0000 - rvx : {32'd0, rvx};
        vy = nvy ? 64'h1_0000_0000 - rvy : {32'd0, rvy};
        s = px * px + py * py;
        fl = (floor_reg == 0) ? 64'd1 : {47'd0, floor_reg};
        t = fl << FRAC_BITS;
        o.clamped = 1'b0;
        if (s < t) begin
            s = t;
            o.clamped = 1'b1;
        end
        r = isqrt(s);
        m1 = vx * py;
        n1 = (nvx != npy) && m1 != 0;
        m2 = vy * px;
        n2 = !((nvy != npx) && m2 != 0) && m2 != 0;
        if (n1 == n2) begin
            c = m1 + m2; nc = n1;
        end else if (m1 >= m2) begin
            c = m1 - m2; nc = n1;
        end else begin
            c = m2 - m1; nc = n2;
        end
        if (c == 0) nc = 1'b0;
        qx = sat_div(128'(px) * 128'(c), s);
        qy = sat_div(128'(py) * 128'(c), s);
        o.jac.range_dx   = to_fixed(npx, sat_div(128'(px) << FRAC_BITS, r));
        o.jac.range_dy   = to_fixed(npy, sat_div(128'(py) << FRAC_BITS, r));
        o.jac.bearing_dx = to_fixed(!npy, sat_div(128'(py) << (2*FRAC_BITS), s));
        o.jac.bearing_dy = to_fixed(npx, sat_div(128'(px) << (2*FRAC_BITS), s));
        o.jac.rate_dx    = to_fixed(npy != nc, sat_div(128'(qy) << FRAC_BITS, r));
        o.jac.rate_dy    = to_fixed(npx == nc, sat_div(128'(qx) << FRAC_BITS, r));
        return o;
    endfunction

    // ---- driving ----
    task automatic send_state(input logic [31:0] px, py, vx, vy);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vy, vx, py, px};
        jac_pending.push_back(jacobian(px, py, vx, vy));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (jac_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [16:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        floor_reg = v;
    endtask

    function automatic logic [31:0] rnd_word;
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return 32'($signed($urandom_range(32'h0010_0000)) - 32'h0008_0000);
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(32'h0400_0000)) - 32'h0200_0000);
        endcase
    endfunction

    task automatic random_block(input int n);
        repeat (n) send_state(rnd_word(), rnd_word(), rnd_word(), rnd_word());
    endtask

    // ---- sink and checking ----
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_jac_res e;
        t_jac got;
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            got = m_axis_tdata;
            if (jac_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", m_axis_tdata);
            end else begin
                e = jac_pending.pop_front();
                if (got !== e.jac || m_axis_tuser[0] !== e.clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b got %h/%b",
                                 e.jac, e.clamped, got, m_axis_tuser[0]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !i_rst_n || sink_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---- directed table ----
    t_row rows[] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0},
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0001_0000},
        '{32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'hFFFF_0000},
        '{32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h1, 32'h1, 32'hFFFF_FFFF, 32'h1, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0100, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000, 32'h0005_0000, 1'b0, 1'b0, 32'h0},
        '{32'hFFFD_0000, 32'hFFFC_0000, 32'h0001_8000, 32'hFFFF_8000, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0002, 32'h0000_0003, 32'h7FFF_0000, 32'h8001_0000, 1'b0, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0}
    };

    initial begin
        t_jac_res e;
        logic [16:0] floors[] = '{17'd0, 17'd1, 17'h1_0000, 17'h1_FFFF, 17'd300};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_state(rows[k].px, rows[k].py, rows[k].vx, rows[k].vy);
            if (rows[k].fixed) begin
                e = jac_pending[$];
                if (e.clamped !== rows[k].clamped || e.jac.range_dx !== rows[k].rdx) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("predictor disagrees with table row %0d", k);
                end
            end
        end
        drain();

        random_block(300);
        drain();

        src_idle_pct = 69;
        foreach (floors[k]) begin
            write_floor(floors[k]);
            send_state(32'h0, 32'h0, 32'h0, 32'h0);
            send_state(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0002);
            random_block(60);
            drain();
        end

        src_idle_pct = 0;
        sink_stall_pct = 69;
        write_floor(17'd7);
        random_block(350);
        drain();

        src_idle_pct = 27;
        sink_stall_pct = 27;
        fork
            random_block(400);
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
        join
        drain();

        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_floor(17'($urandom_range(17'h1_FFFF)));
        random_block(300);
        drain();

        if (mismatches == 0 && jac_pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
